FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the PCX run-length decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/pcxrle_pkg.sv
// Package with the types and constants of the PCX run-length decoder.
package pcxrle_pkg;

    localparam logic [7:0]  RUN_MARK   = 8'hC0;
    localparam logic [5:0]  COUNT_MASK = 6'h3F;

    localparam logic        KIND_PALETTE = 1'b0;
    localparam logic        KIND_DATA    = 1'b1;

    localparam logic        REG_LINE_BYTES  = 1'b0;
    localparam logic        REG_IMAGE_WIDTH = 1'b1;

    localparam logic [15:0] LINE_BYTES_RESET  = 16'd640;
    localparam logic [15:0] IMAGE_WIDTH_RESET = 16'd640;

    // What the column counter says about the byte placed at its current column.
    typedef struct packed {
        logic        visible;
        logic        end_of_row;
        logic        wrap;
        logic [15:0] column;
    } t_place;

endpackage

FILE: rtl/pcxrle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pcxrle_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/pcxrle_line.sv
// Column counter across one scanline, with visibility and line-end decisions.
module pcxrle_line (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [15:0]          i_line_bytes,
    input  logic [15:0]          i_image_width,
    output pcxrle_pkg::t_place   o_place
);

    logic [15:0] r_pos;
    logic [15:0] n_pos;
    logic [16:0] len;
    logic [16:0] vis;
    logic [16:0] nxt;

    always_comb begin
        // A line length of zero stands for 65536 bytes.
        len = (i_line_bytes == 16'd0) ? 17'h10000 : {1'b0, i_line_bytes};
        vis = ({1'b0, i_image_width} < len) ? {1'b0, i_image_width} : len;
        nxt = {1'b0, r_pos} + 17'd1;

        o_place.visible    = ({1'b0, r_pos} < vis);
        o_place.end_of_row = (nxt == vis);
        o_place.wrap       = (nxt >= len);
        o_place.column     = r_pos;

        n_pos = r_pos;
        if (i_step) begin
            n_pos = o_place.wrap ? 16'd0 : nxt[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 16'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

FILE: rtl/pcx_rle_palette_decoder_core.sv
// Top level of the PCX 8-bit run-length decoder with colour table lookup.
//
// Palette writes and run headers are taken in the idle state. A literal byte
// or a run value of n repeats is taken and then emitted before the next item;
// a run stops early at the end of a scanline. The column counter places one
// decoded byte per cycle while the output is free or the column is padding,
// and the colour is read once from the palette memory when the byte is taken.
// A stalled output holds back visible pixels only. The colour table reads as
// zero for entries not yet written since reset, so no clearing pass is needed.
`include "assert_macros.svh"

module pcx_rle_palette_decoder_core #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // data_byte[7:0], palette_index[15:8], palette_rgb[39:16]
    input  logic        s_axis_tuser,  // kind
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // pixel_rgb[23:0], column[39:24]
    output logic        m_axis_tuser,  // end_of_row
    output logic        m_axis_tlast
);

    localparam int         IDX_W     = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

    typedef enum logic {S_IDLE, S_EMIT} t_state;

    t_state      r_state, n_state;
    logic        r_pending, n_pending;
    logic [5:0]  r_run_len, n_run_len;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_hit, n_hit;
    logic [15:0] r_line_bytes, n_line_bytes;
    logic [15:0] r_image_width, n_image_width;
    logic        r_m_valid, n_m_valid;
    logic [23:0] r_pix, n_pix;
    logic [15:0] r_col, n_col;
    logic        r_eor, n_eor;
    logic        r_last, n_last;
    logic        r_valid [PALETTE_ENTRIES];

    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_rgb;
    logic        accept;
    logic        is_header;
    logic        byte_in_range;
    logic        wr_en;
    logic        rd_en;
    logic        out_free;
    logic        step;
    logic [23:0] rd_data;

    pcxrle_pkg::t_place place;

    assign kind          = s_axis_tuser;
    assign data_byte     = s_axis_tdata[7:0];
    assign palette_index = s_axis_tdata[15:8];
    assign palette_rgb   = s_axis_tdata[39:16];

    // Nothing is taken while reset is held.
    assign o_cfg_ready   = i_rst_n;
    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_header     = ((data_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK);
    assign byte_in_range = ({1'b0, data_byte} < PAL_LIMIT);
    assign wr_en         = accept && (kind == pcxrle_pkg::KIND_PALETTE)
                           && ({1'b0, palette_index} < PAL_LIMIT);
    // A run value with a zero count is consumed without any lookup.
    assign rd_en         = accept && (kind == pcxrle_pkg::KIND_DATA)
                           && (r_pending ? (r_run_len != 6'd0) : !is_header);
    assign out_free      = !r_m_valid || m_axis_tready;
    // Padding columns advance without waiting for the output side.
    assign step          = (r_state == S_EMIT) && (!place.visible || out_free);

    pcxrle_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (palette_index[IDX_W-1:0]),
        .i_wr_data (palette_rgb),
        .i_rd_en   (rd_en),
        .i_rd_addr (data_byte[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    pcxrle_line u_line (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_line_bytes  (r_line_bytes),
        .i_image_width (r_image_width),
        .o_place       (place)
    );

    always_comb begin
        n_state       = r_state;
        n_pending     = r_pending;
        n_run_len     = r_run_len;
        n_cnt         = r_cnt;
        n_hit         = r_hit;
        n_line_bytes  = r_line_bytes;
        n_image_width = r_image_width;
        n_m_valid     = r_m_valid && !m_axis_tready;
        n_pix         = r_pix;
        n_col         = r_col;
        n_eor         = r_eor;
        n_last        = r_last;

        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pcxrle_pkg::REG_LINE_BYTES:  n_line_bytes  = i_cfg_data;
                pcxrle_pkg::REG_IMAGE_WIDTH: n_image_width = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept && (kind == pcxrle_pkg::KIND_DATA)) begin
                    n_hit = byte_in_range && r_valid[data_byte[IDX_W-1:0]];
                    if (r_pending) begin
                        n_pending = 1'b0;
                        n_run_len = 6'd0;
                        n_cnt     = r_run_len;
                        if (r_run_len != 6'd0) begin
                            n_state = S_EMIT;
                        end
                    end else if (is_header) begin
                        n_pending = 1'b1;
                        n_run_len = data_byte[5:0] & pcxrle_pkg::COUNT_MASK;
                    end else begin
                        n_cnt   = 6'd1;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (step) begin
                    if (place.visible) begin
                        n_m_valid = 1'b1;
                        n_pix     = r_hit ? rd_data : 24'd0;
                        n_col     = place.column;
                        n_eor     = place.end_of_row;
                        // Visible columns of one item are contiguous, so the
                        // last of them is either the row end or the final repeat.
                        n_last    = place.end_of_row || (r_cnt == 6'd1);
                    end
                    if ((r_cnt == 6'd1) || place.wrap) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt - 6'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pending     <= 1'b0;
            r_run_len     <= 6'd0;
            r_cnt         <= 6'd0;
            r_hit         <= 1'b0;
            r_line_bytes  <= pcxrle_pkg::LINE_BYTES_RESET;
            r_image_width <= pcxrle_pkg::IMAGE_WIDTH_RESET;
            r_m_valid     <= 1'b0;
            r_pix         <= 24'd0;
            r_col         <= 16'd0;
            r_eor         <= 1'b0;
            r_last        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pending     <= n_pending;
            r_run_len     <= n_run_len;
            r_cnt         <= n_cnt;
            r_hit         <= n_hit;
            r_line_bytes  <= n_line_bytes;
            r_image_width <= n_image_width;
            r_m_valid     <= n_m_valid;
            r_pix         <= n_pix;
            r_col         <= n_col;
            r_eor         <= n_eor;
            r_last        <= n_last;
        end
    end

    // An entry reads as black until it has been written after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (wr_en) begin
            r_valid[palette_index[IDX_W-1:0]] <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_col, r_pix};
    assign m_axis_tuser  = r_eor;
    assign m_axis_tlast  = r_last;

    `ASSERT_IMPLIES(a_col_in_width, i_clk, i_rst_n, r_m_valid, r_col < r_image_width)
    `ASSERT_IMPLIES(a_eor_is_last, i_clk, i_rst_n, r_m_valid && r_eor, r_last)
    `ASSERT_IMPLIES(a_emit_count, i_clk, i_rst_n, r_state == S_EMIT, r_cnt != 6'd0)
    `ASSERT_NEXT(a_header_pends, i_clk, i_rst_n,
        accept && (kind == pcxrle_pkg::KIND_DATA) && !r_pending && is_header,
        r_pending && (r_state == S_IDLE))

endmodule

FILE: test/pcx_rle_palette_decoder_core_tb.sv
// Self-checking testbench for the PCX run-length decoder: directed table, then random phases.
module pcx_rle_palette_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcxrle_pkg::*;

    localparam int PALETTE_ENTRIES = 256;
    localparam int SETTLE_CYCLES   = 80;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int MAX_REPORTS     = 10;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 36;

    // How a directed row is checked.
    localparam int PREDICT   = -1;
    localparam int NO_PIXEL  = 0;
    localparam int ONE_PIXEL = 1;

    typedef struct {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  pal_index;
        logic [23:0] pal_rgb;
    } pcx_item_t;

    typedef struct {
        logic [23:0] rgb;
        logic [15:0] column;
        logic        end_of_row;
        logic        last;
    } pixel_t;

    typedef struct {
        bit          is_reg;
        logic        reg_index;
        logic [15:0] reg_value;
        pcx_item_t   item;
        int          typed;
        pixel_t      want;
    } plan_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // data_byte[7:0], palette_index[15:8], palette_rgb[39:16]
    logic        s_axis_tuser = 1'b0;  // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;  // pixel_rgb[23:0], column[39:24]
    logic        m_axis_tuser;  // end_of_row
    logic        m_axis_tlast;

    pcx_rle_palette_decoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoder state as the testbench sees it.
    logic [23:0] colour_table [PALETTE_ENTRIES];
    logic        run_pending;
    logic [5:0]  run_count;
    logic [15:0] line_pos;
    logic [15:0] line_bytes_q;
    logic [15:0] image_width_q;

    pixel_t      decoded[$];
    pixel_t      pending_pixels[$];
    plan_row_t   plan[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    int          stall_left = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    // Places one decoded byte on the scanline; returns 1 when the line ends on it.
    function automatic bit place_byte(input logic [7:0] value);
        logic [16:0] len;
        logic [16:0] vis;
        logic [16:0] nxt;
        pixel_t      px;
        len = (line_bytes_q == 16'd0) ? 17'h10000 : {1'b0, line_bytes_q};
        vis = ({1'b0, image_width_q} < len) ? {1'b0, image_width_q} : len;
        if ({1'b0, line_pos} < vis) begin
            px.rgb        = (int'(value) < PALETTE_ENTRIES) ? colour_table[value] : 24'h0;
            px.column     = line_pos;
            px.end_of_row = ({1'b0, line_pos} + 17'd1 == vis);
            px.last       = 1'b0;
            decoded.push_back(px);
        end
        nxt = {1'b0, line_pos} + 17'd1;
        if (nxt >= len) begin
            line_pos = 16'd0;
            return 1'b1;
        end
        line_pos = nxt[15:0];
        return 1'b0;
    endfunction

    function automatic void decode_item(input pcx_item_t it, input bit keep);
        pixel_t tail;
        decoded.delete();
        if (it.kind == KIND_PALETTE) begin
            if (int'(it.pal_index) < PALETTE_ENTRIES) colour_table[it.pal_index] = it.pal_rgb;
        end else if (run_pending) begin
            run_pending = 1'b0;
            for (int k = 0; k < int'(run_count); k++) begin
                if (place_byte(it.data_byte)) break;
            end
            run_count = '0;
        end else if ((it.data_byte & RUN_MARK) == RUN_MARK) begin
            run_pending = 1'b1;
            run_count   = it.data_byte[5:0] & COUNT_MASK;
        end else begin
            void'(place_byte(it.data_byte));
        end
        if (decoded.size() > 0) begin
            tail      = decoded.pop_back();
            tail.last = 1'b1;
            decoded.push_back(tail);
        end
        if (keep) foreach (decoded[i]) pending_pixels.push_back(decoded[i]);
    endfunction

    function automatic pcx_item_t make_item(input logic kind, input logic [7:0] data_byte);
        pcx_item_t it;
        it.kind      = kind;
        it.data_byte = data_byte;
        it.pal_index = 8'($urandom_range(0, 255));
        it.pal_rgb   = 24'($urandom_range(0, 24'hFFFFFF));
        return it;
    endfunction

    function automatic void plan_reg(input logic idx, input logic [15:0] value);
        plan_row_t row;
        row.is_reg    = 1'b1;
        row.reg_index = idx;
        row.reg_value = value;
        row.typed     = NO_PIXEL;
        plan.push_back(row);
    endfunction

    function automatic void plan_item(input logic kind, input logic [7:0] data_byte,
                                      input logic [7:0] idx, input logic [23:0] rgb,
                                      input int typed = PREDICT, input logic [23:0] px_rgb = '0,
                                      input logic [15:0] column = '0, input logic eor = 1'b0);
        plan_row_t row;
        row.is_reg          = 1'b0;
        row.item.kind       = kind;
        row.item.data_byte  = data_byte;
        row.item.pal_index  = idx;
        row.item.pal_rgb    = rgb;
        row.typed           = typed;
        row.want.rgb        = px_rgb;
        row.want.column     = column;
        row.want.end_of_row = eor;
        row.want.last       = 1'b1;
        plan.push_back(row);
    endfunction

    // Called at a falling edge; holds the request line low until the output has drained.
    task automatic pause_until_drained(input int extra);
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_pixels.size() != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        pause_until_drained(SETTLE_CYCLES);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_LINE_BYTES) line_bytes_q = value;
        else image_width_q = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input pcx_item_t it, input int typed, input pixel_t want);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {it.pal_rgb, it.pal_index, it.data_byte};
        do @(posedge i_clk); while (!s_axis_tready);
        decode_item(it, typed == PREDICT);
        if (typed == ONE_PIXEL) pending_pixels.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic send_random(input logic kind, input logic [7:0] data_byte);
        pixel_t none;
        none = '{default: '0};
        send_item(make_item(kind, data_byte), PREDICT, none);
    endtask

    task automatic random_setting();
        int          r;
        logic [15:0] lb;
        logic [15:0] w;
        int          cap;
        r = $urandom_range(0, 9);
        lb = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
             (r == 2) ? 16'($urandom_range(25, 65535)) : 16'($urandom_range(1, 24));
        cap = (lb != 16'd0 && lb <= 16'd24) ? int'(lb) + 3 : 30;
        r = $urandom_range(0, 9);
        w = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
            (r == 2) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, cap));
        // Leaving a register alone now and then lets a shorter line meet an old column.
        if ($urandom_range(0, 4) != 0) write_reg(REG_LINE_BYTES, lb);
        if ($urandom_range(0, 4) != 0) write_reg(REG_IMAGE_WIDTH, w);
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = (!quiet && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
        end
    end

    always @(posedge i_clk) begin
        pixel_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected pixel: rgb %06h column %0d eor %b last %b",
                             m_axis_tdata[23:0], m_axis_tdata[39:24], m_axis_tuser, m_axis_tlast);
            end else begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata[23:0] !== want.rgb || m_axis_tdata[39:24] !== want.column ||
                    m_axis_tuser !== want.end_of_row || m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"pixel mismatch: expected rgb %06h column %0d eor %b last %b,",
                                  " got rgb %06h column %0d eor %b last %b"},
                                 want.rgb, want.column, want.end_of_row, want.last,
                                 m_axis_tdata[23:0], m_axis_tdata[39:24], m_axis_tuser,
                                 m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int r;
        int sent;
        logic [5:0] count;
        foreach (colour_table[i]) colour_table[i] = 24'h0;
        run_pending   = 1'b0;
        run_count     = '0;
        line_pos      = '0;
        line_bytes_q  = LINE_BYTES_RESET;
        image_width_q = IMAGE_WIDTH_RESET;

        // Straight out of reset the colour table is all zero.
        plan_item(KIND_DATA, 8'h00, 8'h00, 24'h000000, ONE_PIXEL, 24'h000000, 16'd0, 1'b0);
        plan_item(KIND_PALETTE, 8'h00, 8'hFF, 24'hFFFFFF, NO_PIXEL);
        plan_item(KIND_PALETTE, 8'hFF, 8'h00, 24'h5A5A5A, NO_PIXEL);
        plan_item(KIND_DATA, 8'h00, 8'hFF, 24'hFFFFFF, ONE_PIXEL, 24'h5A5A5A, 16'd1, 1'b0);
        plan_item(KIND_DATA, 8'hBF, 8'h00, 24'h000000, ONE_PIXEL, 24'h000000, 16'd2, 1'b0);
        plan_item(KIND_PALETTE, 8'h12, 8'h3F, 24'hA5C31E, NO_PIXEL);
        plan_item(KIND_DATA, 8'h3F, 8'h00, 24'h000000);
        plan_item(KIND_DATA, 8'hC3, 8'h00, 24'h000000, NO_PIXEL);
        plan_item(KIND_DATA, 8'hFF, 8'h00, 24'h000000);
        // A run header with a zero count swallows the next byte.
        plan_item(KIND_DATA, 8'hC0, 8'h00, 24'h000000, NO_PIXEL);
        plan_item(KIND_DATA, 8'hFF, 8'h00, 24'h000000, NO_PIXEL);
        // A palette write between header and value must not disturb the run.
        plan_item(KIND_DATA, 8'hC2, 8'h00, 24'h000000, NO_PIXEL);
        plan_item(KIND_PALETTE, 8'hC0, 8'h80, 24'h800001, NO_PIXEL);
        plan_item(KIND_DATA, 8'h80, 8'h00, 24'h000000);
        plan_item(KIND_DATA, 8'hFF, 8'h00, 24'h000000, NO_PIXEL);
        plan_item(KIND_DATA, 8'hC5, 8'h00, 24'h000000);
        plan_item(KIND_DATA, 8'hC1, 8'h00, 24'h000000, NO_PIXEL);
        plan_item(KIND_DATA, 8'hC1, 8'h00, 24'h000000);
        // The line shrinks below the current column, then a run is cut at the line end.
        plan_reg(REG_LINE_BYTES, 16'd4);
        plan_reg(REG_IMAGE_WIDTH, 16'd2);
        plan_item(KIND_DATA, 8'h3F, 8'h00, 24'h000000);
        plan_item(KIND_DATA, 8'hC5, 8'h00, 24'h000000, NO_PIXEL);
        plan_item(KIND_DATA, 8'h00, 8'h00, 24'h000000);
        plan_reg(REG_IMAGE_WIDTH, 16'd0);
        plan_item(KIND_DATA, 8'h00, 8'h00, 24'h000000);
        plan_reg(REG_LINE_BYTES, 16'd0);
        plan_reg(REG_IMAGE_WIDTH, 16'hFFFF);
        plan_item(KIND_DATA, 8'hC8, 8'h00, 24'h000000, NO_PIXEL);
        plan_item(KIND_DATA, 8'hFF, 8'h00, 24'h000000);
        plan_reg(REG_LINE_BYTES, 16'hFFFF);
        plan_reg(REG_IMAGE_WIDTH, 16'd1);
        plan_item(KIND_DATA, 8'h00, 8'h00, 24'h000000);
        plan_reg(REG_LINE_BYTES, 16'd1);
        plan_reg(REG_IMAGE_WIDTH, 16'hFFFF);
        plan_item(KIND_DATA, 8'hC4, 8'h00, 24'h000000, NO_PIXEL);
        plan_item(KIND_DATA, 8'hFF, 8'h00, 24'h000000);
        plan_item(KIND_DATA, 8'h00, 8'h00, 24'h000000, ONE_PIXEL, 24'h5A5A5A, 16'd0, 1'b1);

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_reg) write_reg(plan[i].reg_index, plan[i].reg_value);
            else send_item(plan[i].item, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            quiet = ($urandom_range(0, 3) == 0);
            random_setting();
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 3) pause_until_drained(0);
                if (r < 12) begin
                    send_random(KIND_PALETTE, 8'($urandom_range(0, 255)));
                    sent += 1;
                end else if (r < 22) begin
                    send_random(KIND_DATA, 8'($urandom_range(0, 255)));
                    sent += 1;
                end else if (r < 55) begin
                    send_random(KIND_DATA, 8'($urandom_range(0, 191)));
                    sent += 1;
                end else begin
                    // Mostly short runs, now and then up to the full count.
                    count = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                        : 6'($urandom_range(0, 6));
                    send_random(KIND_DATA, RUN_MARK | {2'b00, count});
                    sent += 1;
                    if ($urandom_range(0, 9) == 0) begin
                        send_random(KIND_PALETTE, 8'($urandom_range(0, 255)));
                        sent += 1;
                    end
                    send_random(KIND_DATA, 8'($urandom_range(0, 255)));
                    sent += 1;
                end
            end
        end

        pause_until_drained(SETTLE_CYCLES);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pcxrle_pkg.sv
rtl/pcxrle_ram.sv
rtl/pcxrle_line.sv
rtl/pcx_rle_palette_decoder_core.sv
test/pcx_rle_palette_decoder_core_tb.sv
